// ----- rtl/tcms_pkg.sv -----
// Package for the turn count motor sequencer.
// Holds command and phase codes, register indexes, reset values and shared structs.
// No dependencies.
package tcms_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  localparam logic [CfgIdxW-1:0] REG_RESTART_DELAY = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SAFETY_TOUT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RUN_DUTY      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BUSY_BLINK    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IDLE_BLINK    = 3'd4;

  localparam logic [15:0] RESTART_DELAY_RST = 16'd1000;
  localparam logic [15:0] SAFETY_TOUT_RST   = 16'd10000;
  localparam logic [6:0]  RUN_DUTY_RST      = 7'd50;
  localparam logic [15:0] BUSY_BLINK_RST    = 16'd500;
  localparam logic [15:0] IDLE_BLINK_RST    = 16'd1000;
  localparam logic [6:0]  DUTY_MAX          = 7'd100;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_FEED  = 2'd1,
    CMD_PULSE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RUN   = 2'd1,
    PH_PAUSE = 2'd2
  } phase_e;

  typedef struct packed {
    logic [15:0] restart_delay_ms;
    logic [15:0] safety_timeout_ms;
    logic [6:0]  run_duty;
    logic [15:0] busy_blink_ms;
    logic [15:0] idle_blink_ms;
  } cfg_t;

  // packed from the lowest bit: motor_duty first
  typedef struct packed {
    logic        timeout_pulse;
    logic        done_pulse;
    logic [7:0]  turns_done;
    logic [15:0] led_period_ms;
    logic        sensor_enable;
    logic [6:0]  motor_duty;
  } result_t;

endpackage

// ----- rtl/tcms_core.sv -----
// Sequencer state and single-pass update for one input word.
// Depends on tcms_pkg.
module tcms_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  tcms_pkg::cmd_e        command_i,
  input  logic [7:0]            turns_requested_i,
  input  tcms_pkg::cfg_t        cfg_i,
  output tcms_pkg::result_t     result_o
);

  tcms_pkg::phase_e phase_q, phase_d;
  logic [7:0]       turn_count_q, turn_count_d;
  logic [7:0]       turn_target_q, turn_target_d;
  logic [15:0]      phase_timer_q, phase_timer_d;
  logic [15:0]      led_period_q, led_period_d;

  logic [15:0] timer_inc;
  logic [7:0]  count_inc;
  logic [6:0]  duty;
  logic        done;
  logic        tout;

  assign timer_inc = (phase_timer_q == 16'hFFFF) ? phase_timer_q : phase_timer_q + 16'd1;
  assign count_inc = (turn_count_q == 8'hFF) ? turn_count_q : turn_count_q + 8'd1;
  assign duty      = (cfg_i.run_duty > tcms_pkg::DUTY_MAX) ? tcms_pkg::DUTY_MAX : cfg_i.run_duty;

  always_comb begin
    phase_d       = phase_q;
    turn_count_d  = turn_count_q;
    turn_target_d = turn_target_q;
    phase_timer_d = phase_timer_q;
    led_period_d  = led_period_q;
    done          = 1'b0;
    tout          = 1'b0;
    case (command_i)
      tcms_pkg::CMD_TICK: begin
        case (phase_q)
          tcms_pkg::PH_RUN: begin
            phase_timer_d = timer_inc;
            if (timer_inc >= cfg_i.safety_timeout_ms) begin
              phase_d       = tcms_pkg::PH_IDLE;
              phase_timer_d = '0;
              led_period_d  = cfg_i.idle_blink_ms;
              tout          = 1'b1;
            end
          end
          tcms_pkg::PH_PAUSE: begin
            phase_timer_d = timer_inc;
            if (timer_inc >= cfg_i.restart_delay_ms) begin
              phase_d       = tcms_pkg::PH_RUN;
              phase_timer_d = '0;
            end
          end
          default: ;
        endcase
      end
      tcms_pkg::CMD_FEED: begin
        turn_target_d = turns_requested_i;
        if (phase_q == tcms_pkg::PH_PAUSE) begin
          phase_d       = tcms_pkg::PH_IDLE;
          phase_timer_d = '0;
        end
        if (turns_requested_i != 8'd0) begin
          led_period_d  = cfg_i.busy_blink_ms;
          phase_d       = tcms_pkg::PH_RUN;
          phase_timer_d = '0;
        end
      end
      tcms_pkg::CMD_PULSE: begin
        if (phase_q == tcms_pkg::PH_RUN) begin
          phase_timer_d = '0;
          if (count_inc >= turn_target_q) begin
            turn_count_d  = '0;
            turn_target_d = '0;
            led_period_d  = cfg_i.idle_blink_ms;
            phase_d       = tcms_pkg::PH_IDLE;
            done          = 1'b1;
          end else begin
            turn_count_d = count_inc;
            phase_d      = tcms_pkg::PH_PAUSE;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.motor_duty    = (phase_d == tcms_pkg::PH_RUN) ? duty : 7'd0;
    result_o.sensor_enable = (phase_d == tcms_pkg::PH_RUN);
    result_o.led_period_ms = led_period_d;
    result_o.turns_done    = turn_count_d;
    result_o.done_pulse    = done;
    result_o.timeout_pulse = tout;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= tcms_pkg::PH_IDLE;
      turn_count_q  <= '0;
      turn_target_q <= '0;
      phase_timer_q <= '0;
      led_period_q  <= tcms_pkg::IDLE_BLINK_RST;
    end else if (item_valid_i) begin
      phase_q       <= phase_d;
      turn_count_q  <= turn_count_d;
      turn_target_q <= turn_target_d;
      phase_timer_q <= phase_timer_d;
      led_period_q  <= led_period_d;
    end
  end

endmodule

// ----- rtl/turn_count_motor_sequencer.sv -----
// Turn count motor sequencer: top level with config registers and output skid stage.
// Depends on tcms_pkg and tcms_core.
// Each accepted input word yields a result word, registered in the output stage or held in the skid register.
// Throughput: one word per cycle while s_axis_tready is high; the state update is a single pass through tcms_core.
// s_axis_tready drops only while the skid register holds a word behind a stalled output.
// Reset clears sequencer state to idle, LED period to 1000, config to default values.
module turn_count_motor_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [1:0] command, [9:2] turns_requested, zero fill above
  input  logic [tcms_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [6:0] motor_duty, [7] sensor_enable, [23:8] led_period_ms, [31:24] turns_done,
  // [32] done_pulse, [33] timeout_pulse, zero fill above
  output logic [tcms_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [tcms_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tcms_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned ResW = $bits(tcms_pkg::result_t);

  tcms_pkg::cfg_t    cfg_q;
  tcms_pkg::result_t res;
  tcms_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic              out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic              accept;

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.restart_delay_ms  <= tcms_pkg::RESTART_DELAY_RST;
      cfg_q.safety_timeout_ms <= tcms_pkg::SAFETY_TOUT_RST;
      cfg_q.run_duty          <= tcms_pkg::RUN_DUTY_RST;
      cfg_q.busy_blink_ms     <= tcms_pkg::BUSY_BLINK_RST;
      cfg_q.idle_blink_ms     <= tcms_pkg::IDLE_BLINK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcms_pkg::REG_RESTART_DELAY: cfg_q.restart_delay_ms  <= cfg_data_i;
        tcms_pkg::REG_SAFETY_TOUT:   cfg_q.safety_timeout_ms <= cfg_data_i;
        tcms_pkg::REG_RUN_DUTY:      cfg_q.run_duty          <= cfg_data_i[6:0];
        tcms_pkg::REG_BUSY_BLINK:    cfg_q.busy_blink_ms     <= cfg_data_i;
        tcms_pkg::REG_IDLE_BLINK:    cfg_q.idle_blink_ms     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcms_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (accept),
    .command_i         (tcms_pkg::cmd_e'(s_axis_tdata[1:0])),
    .turns_requested_i (s_axis_tdata[9:2]),
    .cfg_i             (cfg_q),
    .result_o          (res)
  );

  // output register plus skid word
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_valid_q && !m_axis_tready) begin
      if (accept) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (skid_valid_q) begin
      out_d        = skid_q;
      out_valid_d  = 1'b1;
      skid_valid_d = accept;
      if (accept) begin
        skid_d = res;
      end
    end else begin
      out_valid_d = accept;
      if (accept) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(tcms_pkg::OutDataW - ResW){1'b0}}, out_q};

endmodule

// ----- tb/turn_count_motor_sequencer_tb.sv -----
// Self-checking testbench for the turn count motor sequencer.
// Drives stream words and register writes, predicts every result word, compares fields.
// Depends on tcms_pkg and turn_count_motor_sequencer.
`timescale 1ns / 100ps

module turn_count_motor_sequencer_tb;

  localparam int unsigned PhaseWords = 185;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned HoldAt     = 300;
  localparam int unsigned HoldCycles = 120;

  typedef struct {
    bit                           is_cfg;
    logic [tcms_pkg::CfgIdxW-1:0] idx;
    logic [15:0]                  val;
    tcms_pkg::cmd_e               cmd;
    logic [7:0]                   req;
    bit                           typed;
    tcms_pkg::result_t            res;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [tcms_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [tcms_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          cfg_we_i      = 1'b0;
  logic [tcms_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [tcms_pkg::CfgDataW-1:0] cfg_data_i    = '0;

  turn_count_motor_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predicted sequencer state and registers
  tcms_pkg::phase_e seq_phase;
  logic [7:0]       seq_count;
  logic [7:0]       seq_target;
  logic [15:0]      seq_timer;
  logic [15:0]      seq_led;
  logic [15:0]      delay_reg;
  logic [15:0]      tout_reg;
  logic [6:0]       duty_reg;
  logic [15:0]      busy_reg;
  logic [15:0]      idle_reg;

  tcms_pkg::result_t pending_results[$];
  dir_row_t          dir_tbl[$];

  int unsigned       src_idle_pct = 33;
  int unsigned       rcv_idle_pct = 82;
  int unsigned       words_out    = 0;
  int unsigned       hold_left    = 0;
  bit                held         = 1'b0;
  int unsigned       fail_cnt     = 0;
  tcms_pkg::result_t got_res;
  tcms_pkg::result_t want_res;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic tcms_pkg::result_t step_sequencer(input tcms_pkg::cmd_e cmd,
                                                       input logic [7:0] req);
    tcms_pkg::result_t res;
    res = '0;
    case (cmd)
      tcms_pkg::CMD_TICK: begin
        if (seq_phase == tcms_pkg::PH_RUN) begin
          if (seq_timer != 16'hFFFF) seq_timer = seq_timer + 16'd1;
          if (seq_timer >= tout_reg) begin
            seq_phase = tcms_pkg::PH_IDLE;
            seq_timer = '0;
            seq_led = idle_reg;
            res.timeout_pulse = 1'b1;
          end
        end else if (seq_phase == tcms_pkg::PH_PAUSE) begin
          if (seq_timer != 16'hFFFF) seq_timer = seq_timer + 16'd1;
          if (seq_timer >= delay_reg) begin
            seq_phase = tcms_pkg::PH_RUN;
            seq_timer = '0;
          end
        end
      end
      tcms_pkg::CMD_FEED: begin
        seq_target = req;
        if (seq_phase == tcms_pkg::PH_PAUSE) begin
          seq_phase = tcms_pkg::PH_IDLE;
          seq_timer = '0;
        end
        if (req != 8'd0) begin
          seq_led = busy_reg;
          seq_phase = tcms_pkg::PH_RUN;
          seq_timer = '0;
        end
      end
      tcms_pkg::CMD_PULSE: begin
        if (seq_phase == tcms_pkg::PH_RUN) begin
          if (seq_count != 8'hFF) seq_count = seq_count + 8'd1;
          seq_timer = '0;
          if (seq_count >= seq_target) begin
            seq_count = '0;
            seq_target = '0;
            seq_led = idle_reg;
            seq_phase = tcms_pkg::PH_IDLE;
            res.done_pulse = 1'b1;
          end else begin
            seq_phase = tcms_pkg::PH_PAUSE;
          end
        end
      end
      default: ;
    endcase
    if (seq_phase == tcms_pkg::PH_RUN) begin
      res.motor_duty = (duty_reg > tcms_pkg::DUTY_MAX) ? tcms_pkg::DUTY_MAX : duty_reg;
      res.sensor_enable = 1'b1;
    end
    res.led_period_ms = seq_led;
    res.turns_done = seq_count;
    return res;
  endfunction

  function automatic void dir_cfg(input logic [tcms_pkg::CfgIdxW-1:0] idx,
                                  input logic [15:0] val);
    dir_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, val: val, cmd: tcms_pkg::CMD_NONE, req: '0,
            typed: 1'b0, res: '0};
    dir_tbl.push_back(row);
  endfunction

  function automatic void dir_item(input tcms_pkg::cmd_e cmd, input logic [7:0] req);
    dir_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, val: '0, cmd: cmd, req: req, typed: 1'b0, res: '0};
    dir_tbl.push_back(row);
  endfunction

  function automatic void dir_chk(input tcms_pkg::cmd_e cmd, input logic [7:0] req,
                                  input logic [6:0] duty, input logic sen,
                                  input logic [15:0] led, input logic [7:0] turns,
                                  input logic done, input logic tout);
    dir_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, val: '0, cmd: cmd, req: req, typed: 1'b1, res: '0};
    row.res = '{timeout_pulse: tout, done_pulse: done, turns_done: turns,
                led_period_ms: led, sensor_enable: sen, motor_duty: duty};
    dir_tbl.push_back(row);
  endfunction

  task automatic write_reg(input logic [tcms_pkg::CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      tcms_pkg::REG_RESTART_DELAY: delay_reg = val;
      tcms_pkg::REG_SAFETY_TOUT:   tout_reg  = val;
      tcms_pkg::REG_RUN_DUTY:      duty_reg  = val[6:0];
      tcms_pkg::REG_BUSY_BLINK:    busy_reg  = val;
      tcms_pkg::REG_IDLE_BLINK:    idle_reg  = val;
      default: ;
    endcase
  endtask

  task automatic send_word(input tcms_pkg::cmd_e cmd, input logic [7:0] req);
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, req, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side: check, random backpressure, one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = m_axis_tdata[$bits(tcms_pkg::result_t)-1:0];
      words_out++;
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected word: %h", got_res);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.motor_duty !== want_res.motor_duty ||
            got_res.sensor_enable !== want_res.sensor_enable ||
            got_res.led_period_ms !== want_res.led_period_ms ||
            got_res.turns_done !== want_res.turns_done ||
            got_res.done_pulse !== want_res.done_pulse ||
            got_res.timeout_pulse !== want_res.timeout_pulse) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("word %0d: ", words_out,
                     "exp duty=%0d sen=%0b led=%0d turns=%0d done=%0b tout=%0b, ",
                     want_res.motor_duty, want_res.sensor_enable,
                     want_res.led_period_ms, want_res.turns_done, want_res.done_pulse,
                     want_res.timeout_pulse,
                     "got duty=%0d sen=%0b led=%0d turns=%0d done=%0b tout=%0b",
                     got_res.motor_duty, got_res.sensor_enable,
                     got_res.led_period_ms, got_res.turns_done, got_res.done_pulse,
                     got_res.timeout_pulse);
        end
      end
    end
    if (words_out == HoldAt && !held) begin
      held = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    tcms_pkg::result_t res;
    dir_row_t          row;
    tcms_pkg::cmd_e    cmd;
    logic [7:0]        req;
    int unsigned       roll;
    int unsigned       cnt;
    logic [15:0]       v_delay, v_tout, v_duty, v_busy, v_idle;

    seq_phase  = tcms_pkg::PH_IDLE;
    seq_count  = '0;
    seq_target = '0;
    seq_timer  = '0;
    delay_reg  = tcms_pkg::RESTART_DELAY_RST;
    tout_reg   = tcms_pkg::SAFETY_TOUT_RST;
    duty_reg   = tcms_pkg::RUN_DUTY_RST;
    busy_reg   = tcms_pkg::BUSY_BLINK_RST;
    idle_reg   = tcms_pkg::IDLE_BLINK_RST;
    seq_led    = tcms_pkg::IDLE_BLINK_RST;

    // reset values, ignored and unused commands, zero request
    dir_chk(tcms_pkg::CMD_TICK,  8'h00, 7'd0, 1'b0, 16'd1000, 8'd0, 1'b0, 1'b0);
    dir_chk(tcms_pkg::CMD_NONE,  8'hFF, 7'd0, 1'b0, 16'd1000, 8'd0, 1'b0, 1'b0);
    dir_chk(tcms_pkg::CMD_PULSE, 8'hAA, 7'd0, 1'b0, 16'd1000, 8'd0, 1'b0, 1'b0);
    dir_chk(tcms_pkg::CMD_FEED,  8'h00, 7'd0, 1'b0, 16'd1000, 8'd0, 1'b0, 1'b0);
    // duty above range, zero restart delay
    dir_cfg(tcms_pkg::REG_RUN_DUTY, 16'd127);
    dir_cfg(tcms_pkg::REG_RESTART_DELAY, 16'd0);
    dir_cfg(tcms_pkg::REG_SAFETY_TOUT, 16'd2);
    dir_chk(tcms_pkg::CMD_FEED, 8'd3, 7'd100, 1'b1, 16'd500, 8'd0, 1'b0, 1'b0);
    dir_item(tcms_pkg::CMD_PULSE, 8'h55);
    dir_item(tcms_pkg::CMD_TICK, 8'h00);
    dir_item(tcms_pkg::CMD_PULSE, 8'h00);
    // new target below count, next pulse completes
    dir_item(tcms_pkg::CMD_FEED, 8'd1);
    dir_chk(tcms_pkg::CMD_PULSE, 8'h00, 7'd0, 1'b0, 16'd1000, 8'd0, 1'b1, 1'b0);
    dir_item(tcms_pkg::CMD_FEED, 8'd255);
    dir_item(tcms_pkg::CMD_TICK, 8'h00);
    dir_chk(tcms_pkg::CMD_TICK, 8'h00, 7'd0, 1'b0, 16'd1000, 8'd0, 1'b0, 1'b1);
    // request while running restarts the safety timer
    dir_item(tcms_pkg::CMD_FEED, 8'd2);
    dir_item(tcms_pkg::CMD_TICK, 8'h00);
    dir_item(tcms_pkg::CMD_FEED, 8'd2);
    dir_chk(tcms_pkg::CMD_TICK, 8'h00, 7'd100, 1'b1, 16'd500, 8'd0, 1'b0, 1'b0);
    dir_chk(tcms_pkg::CMD_TICK, 8'h00, 7'd0, 1'b0, 16'd1000, 8'd0, 1'b0, 1'b1);
    // zero request while running: keeps running, next pulse completes
    dir_item(tcms_pkg::CMD_FEED, 8'd2);
    dir_item(tcms_pkg::CMD_FEED, 8'd0);
    dir_chk(tcms_pkg::CMD_PULSE, 8'h00, 7'd0, 1'b0, 16'd1000, 8'd0, 1'b1, 1'b0);
    // zero timeout, zero duty, zero busy blink, top restart delay and idle blink
    dir_cfg(tcms_pkg::REG_RESTART_DELAY, 16'hFFFF);
    dir_cfg(tcms_pkg::REG_SAFETY_TOUT, 16'd0);
    dir_cfg(tcms_pkg::REG_RUN_DUTY, 16'd0);
    dir_cfg(tcms_pkg::REG_BUSY_BLINK, 16'd0);
    dir_cfg(tcms_pkg::REG_IDLE_BLINK, 16'hFFFF);
    dir_chk(tcms_pkg::CMD_FEED, 8'd5, 7'd0, 1'b1, 16'd0, 8'd0, 1'b0, 1'b0);
    dir_chk(tcms_pkg::CMD_TICK, 8'h00, 7'd0, 1'b0, 16'hFFFF, 8'd0, 1'b0, 1'b1);
    // zero request cancels a pending restart
    dir_item(tcms_pkg::CMD_FEED, 8'd5);
    dir_item(tcms_pkg::CMD_PULSE, 8'h00);
    dir_item(tcms_pkg::CMD_FEED, 8'd0);
    dir_item(tcms_pkg::CMD_TICK, 8'h00);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      if (row.is_cfg) begin
        drain();
        write_reg(row.idx, row.val);
      end else begin
        send_word(row.cmd, row.req);
        res = step_sequencer(row.cmd, row.req);
        pending_results.push_back(row.typed ? row.res : res);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      src_idle_pct = (p < 2) ? 33 : (p < 4) ? 82 : 0;
      rcv_idle_pct = (p < 2) ? 82 : (p < 4) ? 33 : 0;
      case (p)
        1: begin
          v_delay = 16'hFFFF; v_tout = 16'hFFFF; v_duty = 16'd100;
          v_busy = 16'hFFFF; v_idle = 16'd0;
        end
        2: begin
          v_delay = 16'd1; v_tout = 16'd1; v_duty = 16'd0;
          v_busy = 16'd1; v_idle = 16'd1;
        end
        default: begin
          v_delay = 16'($urandom_range(6));
          v_tout  = 16'($urandom_range(20, 1));
          v_duty  = 16'($urandom);
          v_busy  = 16'($urandom);
          v_idle  = 16'($urandom);
        end
      endcase
      write_reg(tcms_pkg::REG_RESTART_DELAY, v_delay);
      write_reg(tcms_pkg::REG_SAFETY_TOUT, v_tout);
      write_reg(tcms_pkg::REG_RUN_DUTY, v_duty);
      write_reg(tcms_pkg::REG_BUSY_BLINK, v_busy);
      write_reg(tcms_pkg::REG_IDLE_BLINK, v_idle);

      cnt = 0;
      while (cnt < PhaseWords) begin
        roll = $urandom_range(99);
        if (roll < 55)      cmd = tcms_pkg::CMD_TICK;
        else if (roll < 80) cmd = tcms_pkg::CMD_PULSE;
        else if (roll < 93) cmd = tcms_pkg::CMD_FEED;
        else                cmd = tcms_pkg::CMD_NONE;
        req = ($urandom_range(99) < 75) ? 8'($urandom_range(4)) : 8'($urandom);
        cnt++;
        send_word(cmd, req);
        pending_results.push_back(step_sequencer(cmd, req));
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tcms_pkg.sv
rtl/tcms_core.sv
rtl/turn_count_motor_sequencer.sv
tb/turn_count_motor_sequencer_tb.sv
